>>> design/rft_pkg.sv
// Shared constants and types for the rail fence transposer.
// No dependencies; imported by every module of the block but rft_ram.
package rft_pkg;

    localparam int RFT_MAX_LEN   = 64;
    localparam int RFT_BYTE_W    = 8;
    localparam int RFT_LEN_W     = 7;
    localparam int RFT_ROWS_W    = 7;
    localparam int RFT_NUM_BANKS = 2;

    localparam logic [RFT_ROWS_W-1:0] RFT_ROWS_RESET = 7'd3;

    // One finished message waiting to be read out of its bank
    typedef struct packed {
        logic                  bank;
        logic [RFT_LEN_W-1:0]  len;
        logic [RFT_ROWS_W-1:0] rows;
        logic                  ovf;
    } rft_job_t;

endpackage

>>> design/rail_fence_transposer.sv
// Top level of the rail fence transposer: loader, job queue, drain, and a
// double-banked message RAM. Depends on rft_pkg and all rft_* modules.
//
//  port group  | dir | handshake        | payload
//  ------------+-----+------------------+-------------------------------------
//  s_*         | in  | s_valid/s_ready  | s_in_byte[7:0], s_in_last
//  m_*         | out | m_valid/m_ready  | m_out_byte[7:0], m_out_last, m_overflow
//  cfg_*       | in  | cfg_wr_en        | cfg_wr_data[6:0] (row count)
//
// Loading takes one input byte per cycle while s_ready is high. Draining reads
// one byte per cycle through the single read port of the message RAM, stalling
// while the output queue is full and skipping zigzag slots past the message end;
// read data passes the RAM output register, then the output queue, to m_*.
// Two RAM banks let the next message load while one drains; s_ready drops only
// while both banks hold messages not yet read out.
// Reset clears the counters, queues and flags at once; no clearing pass.
module rail_fence_transposer
    import rft_pkg::*;
#(
    parameter int MAX_LEN = RFT_MAX_LEN
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [RFT_BYTE_W-1:0] s_in_byte,
    input  logic                  s_in_last,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [RFT_BYTE_W-1:0] m_out_byte,
    output logic                  m_out_last,
    output logic                  m_overflow,
    input  logic                  cfg_wr_en,
    input  logic [RFT_ROWS_W-1:0] cfg_wr_data
);

    // each bank spans a power-of-two address range so {bank, offset} stays in range
    localparam int RAM_DEPTH = RFT_NUM_BANKS * (2 ** $clog2(MAX_LEN));
    localparam int RAW       = $clog2(RAM_DEPTH);

    logic                  ram_wr_en;
    logic [RAW-1:0]        ram_wr_addr;
    logic [RFT_BYTE_W-1:0] ram_wr_data;
    logic                  ram_rd_en;
    logic [RAW-1:0]        ram_rd_addr;
    logic [RFT_BYTE_W-1:0] ram_rd_data;

    logic     q_push, q_pop, q_full, q_valid;
    rft_job_t q_push_job, q_head_job;

    rft_loader #(
        .MAX_LEN(MAX_LEN)
    ) u_loader (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .s_in_last   (s_in_last),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_job       (q_push_job)
    );

    rft_job_queue u_job_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (q_push_job),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_job   (q_head_job),
        .full       (q_full)
    );

    rft_ram #(
        .WIDTH(RFT_BYTE_W),
        .DEPTH(RAM_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    rft_drain #(
        .MAX_LEN(MAX_LEN)
    ) u_drain (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_job       (q_head_job),
        .q_pop       (q_pop),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_out_last  (m_out_last),
        .m_overflow  (m_overflow)
    );

endmodule

>>> design/rft_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> design/rft_job_queue.sv
// Two-entry queue of finished message descriptors between loader and drain.
// Depends on rft_pkg.
module rft_job_queue
    import rft_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  rft_job_t push_job,
    input  logic     pop,
    output logic     head_valid,
    output rft_job_t head_job,
    output logic     full
);

    logic [1:0] count_reg, count_next;
    rft_job_t   e0_reg, e1_reg;
    logic [1:0] after_pop;

    assign head_valid = (count_reg != 2'd0);
    assign head_job   = e0_reg;
    assign full       = (count_reg == 2'd2);
    assign after_pop  = count_reg - {1'b0, pop};

    always_comb begin
        count_next = after_pop + {1'b0, push};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            e0_reg <= e1_reg;
        end
        if (push) begin
            if (after_pop == 2'd0) begin
                e0_reg <= push_job;
            end else begin
                e1_reg <= push_job;
            end
        end
    end

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && full) |-> pop)
        else $error("job pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("job popped from an empty queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("job queue count out of range");

endmodule

>>> design/rft_loader.sv
// Front end: takes input transactions, writes bytes into the current bank,
// tracks overflow and hands a descriptor to the job queue on the last byte.
// Depends on rft_pkg.
module rft_loader
    import rft_pkg::*;
#(
    parameter int MAX_LEN = RFT_MAX_LEN
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [RFT_BYTE_W-1:0]           s_in_byte,
    input  logic                            s_in_last,
    input  logic                            cfg_wr_en,
    input  logic [RFT_ROWS_W-1:0]           cfg_wr_data,
    output logic                            ram_wr_en,
    output logic [$clog2(MAX_LEN):0]        ram_wr_addr,
    output logic [RFT_BYTE_W-1:0]           ram_wr_data,
    input  logic                            q_full,
    output logic                            q_push,
    output rft_job_t                        q_job
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);

    logic [LW-1:0]         cnt_reg, cnt_next;
    logic                  bank_reg, bank_next;
    logic                  ovf_reg, ovf_next;
    logic [RFT_ROWS_W-1:0] rows_reg;
    logic                  accept;
    logic                  has_room;
    logic [LW-1:0]         cnt_inc;

    // A free bank exists whenever the queue has room for another message
    assign s_ready  = !q_full;
    assign accept   = s_valid && s_ready;
    assign has_room = (cnt_reg < LW'(MAX_LEN));
    assign cnt_inc  = has_room ? cnt_reg + LW'(1) : cnt_reg;

    assign ram_wr_en   = accept && has_room;
    assign ram_wr_addr = {bank_reg, cnt_reg[AW-1:0]};
    assign ram_wr_data = s_in_byte;

    assign q_push   = accept && s_in_last;
    assign q_job.bank = bank_reg;
    assign q_job.len  = RFT_LEN_W'(cnt_inc);
    assign q_job.rows = rows_reg;
    assign q_job.ovf  = ovf_next;

    always_comb begin
        cnt_next  = cnt_reg;
        bank_next = bank_reg;
        ovf_next  = ovf_reg;
        if (accept) begin
            if (!has_room) begin
                ovf_next = 1'b1;
            end
            if (s_in_last) begin
                cnt_next  = '0;
                bank_next = !bank_reg;
            end else begin
                cnt_next = cnt_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            bank_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            rows_reg <= RFT_ROWS_RESET;
        end else begin
            cnt_reg  <= cnt_next;
            bank_reg <= bank_next;
            ovf_reg  <= ovf_next;
            if (cfg_wr_en) begin
                rows_reg <= cfg_wr_data;
            end
        end
    end

endmodule

>>> design/rft_drain.sv
// Back end: walks the zigzag order of the message at the queue head, reads
// its bank and feeds a two-entry output queue to the result channel.
// Depends on rft_pkg.
module rft_drain
    import rft_pkg::*;
#(
    parameter int MAX_LEN = RFT_MAX_LEN
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     q_valid,
    input  rft_job_t                 q_job,
    output logic                     q_pop,
    output logic                     ram_rd_en,
    output logic [$clog2(MAX_LEN):0] ram_rd_addr,
    input  logic [RFT_BYTE_W-1:0]    ram_rd_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [RFT_BYTE_W-1:0]    m_out_byte,
    output logic                     m_out_last,
    output logic                     m_overflow
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int BW = $clog2(3 * MAX_LEN);
    localparam int CW = (BW > RFT_LEN_W) ? BW : RFT_LEN_W;

    typedef struct packed {
        logic [RFT_BYTE_W-1:0] data;
        logic                  last;
        logic                  ovf;
    } rft_out_t;

    logic                  busy_reg, busy_next;
    logic                  pass_reg, pass_next;
    logic [RFT_ROWS_W-1:0] rlast_reg, rlast_next;
    logic [BW-1:0]         per_reg, per_next;
    logic [RFT_ROWS_W-1:0] row_reg, row_next;
    logic [BW-1:0]         base_reg, base_next;
    logic                  phase_reg, phase_next;
    logic [LW-1:0]         issued_reg, issued_next;

    logic                  pend_reg, pend_last_reg, pend_ovf_reg;
    logic [1:0]            ocnt_reg, ocnt_next;
    rft_out_t              o0_reg, o1_reg;

    logic [RFT_ROWS_W-1:0] rows_eff;
    logic [RFT_ROWS_W:0]   per_wide;
    logic                  middle;
    logic [BW-1:0]         cand;
    logic                  cand_ok;
    logic                  can_issue;
    logic                  issue;
    logic                  step;
    logic                  is_last;
    logic                  pop_out;
    logic [1:0]            occ;
    logic [1:0]            ocnt_after_pop;
    logic [BW-1:0]         base_adv;
    rft_out_t              push_ent;

    // per-message setup, from the descriptor at the queue head
    assign rows_eff = (q_job.rows == '0) ? RFT_ROWS_W'(1) : q_job.rows;
    assign per_wide = {rows_eff - RFT_ROWS_W'(1), 1'b0};

    assign middle = (row_reg != '0) && (row_reg != rlast_reg);

    always_comb begin
        if (pass_reg) begin
            cand = BW'(issued_reg);
        end else if (middle && phase_reg) begin
            cand = base_reg + per_reg - BW'(row_reg);
        end else if (row_reg == '0) begin
            cand = base_reg;
        end else begin
            cand = base_reg + BW'(row_reg);
        end
    end

    assign cand_ok  = (CW'(cand) < CW'(q_job.len));
    assign is_last  = (RFT_LEN_W'(issued_reg) == q_job.len - RFT_LEN_W'(1));
    assign base_adv = base_reg + per_reg;

    // room in the output queue counting the read in flight
    assign pop_out   = m_valid && m_ready;
    assign occ       = ocnt_reg + {1'b0, pend_reg};
    assign can_issue = (occ < 2'd2) || ((occ == 2'd2) && pop_out);

    assign issue = busy_reg && cand_ok && can_issue;
    assign step  = busy_reg && (!cand_ok || can_issue);
    assign q_pop = issue && is_last;

    assign ram_rd_en   = issue;
    assign ram_rd_addr = {q_job.bank, cand[AW-1:0]};

    always_comb begin
        busy_next   = busy_reg;
        pass_next   = pass_reg;
        rlast_next  = rlast_reg;
        per_next    = per_reg;
        row_next    = row_reg;
        base_next   = base_reg;
        phase_next  = phase_reg;
        issued_next = issued_reg;
        if (!busy_reg) begin
            if (q_valid) begin
                busy_next   = 1'b1;
                pass_next   = (rows_eff == RFT_ROWS_W'(1)) || (q_job.len <= rows_eff);
                rlast_next  = rows_eff - RFT_ROWS_W'(1);
                per_next    = BW'(per_wide);
                row_next    = '0;
                base_next   = '0;
                phase_next  = 1'b0;
                issued_next = '0;
            end
        end else if (step) begin
            if (issue) begin
                issued_next = issued_reg + LW'(1);
                if (is_last) begin
                    busy_next = 1'b0;
                end
            end
            if (!pass_reg) begin
                if (middle && !phase_reg) begin
                    phase_next = 1'b1;
                end else begin
                    phase_next = 1'b0;
                    if (CW'(base_adv) >= CW'(q_job.len)) begin
                        base_next = '0;
                        row_next  = row_reg + RFT_ROWS_W'(1);
                    end else begin
                        base_next = base_adv;
                    end
                end
            end
        end
    end

    assign ocnt_after_pop = ocnt_reg - {1'b0, pop_out};
    assign push_ent.data  = ram_rd_data;
    assign push_ent.last  = pend_last_reg;
    assign push_ent.ovf   = pend_ovf_reg;

    always_comb begin
        ocnt_next = ocnt_after_pop + {1'b0, pend_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pend_reg <= 1'b0;
            ocnt_reg <= 2'd0;
        end else begin
            busy_reg <= busy_next;
            pend_reg <= issue;
            ocnt_reg <= ocnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        pass_reg      <= pass_next;
        rlast_reg     <= rlast_next;
        per_reg       <= per_next;
        row_reg       <= row_next;
        base_reg      <= base_next;
        phase_reg     <= phase_next;
        issued_reg    <= issued_next;
        pend_last_reg <= is_last;
        pend_ovf_reg  <= q_job.ovf;
        if (pop_out) begin
            o0_reg <= o1_reg;
        end
        if (pend_reg) begin
            if (ocnt_after_pop == 2'd0) begin
                o0_reg <= push_ent;
            end else begin
                o1_reg <= push_ent;
            end
        end
    end

    assign m_valid    = (ocnt_reg != 2'd0);
    assign m_out_byte = o0_reg.data;
    assign m_out_last = o0_reg.last;
    assign m_overflow = o0_reg.ovf;

    a_busy_has_job: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> q_valid)
        else $error("drain busy without a queued message");

    a_out_room: assert property (@(posedge aclk) disable iff (!aresetn)
        occ <= 2'd2)
        else $error("output queue overrun");

    a_issue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (RFT_LEN_W'(issued_reg) < q_job.len))
        else $error("more bytes issued than the message holds");

    a_pop_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> !busy_reg)
        else $error("drain still busy after its message was retired");

endmodule

>>> verif/tb_rail_fence_transposer.sv
`timescale 1ns / 1ps
// Self-checking testbench for rail_fence_transposer: a queue-fed driver, a monitor
// checked against an in-bench zigzag predictor, random idling and back-pressure.
// Depends on rft_pkg and the design sources of the block.
module tb_rail_fence_transposer;
    import rft_pkg::*;

    typedef struct {
        logic [RFT_BYTE_W-1:0] data;
        logic                  last;
    } msg_item_t;

    typedef struct {
        logic [RFT_BYTE_W-1:0] data;
        logic                  last;
        logic                  ovf;
    } fence_out_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic [RFT_BYTE_W-1:0] s_in_byte   = '0;
    logic                  s_in_last   = 1'b0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic [RFT_BYTE_W-1:0] m_out_byte;
    logic                  m_out_last;
    logic                  m_overflow;
    logic                  cfg_wr_en   = 1'b0;
    logic [RFT_ROWS_W-1:0] cfg_wr_data = '0;

    msg_item_t  msg_items_q[$];
    fence_out_t transposed_q[$];

    // Predictor state
    logic [RFT_BYTE_W-1:0] msg_store [RFT_MAX_LEN];
    int                    held_len  = 0;
    logic                  drop_seen = 1'b0;
    logic [RFT_ROWS_W-1:0] rows_cfg  = RFT_ROWS_RESET;

    int err_count = 0;
    bit idle_en   = 1'b0;
    int hold_req  = 0;
    bit s_taken   = 1'b0;

    rail_fence_transposer uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .s_in_last   (s_in_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_out_last  (m_out_last),
        .m_overflow  (m_overflow),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #10 aclk = ~aclk;

    // Reorder the held message row by row along the zigzag and queue the results
    task automatic queue_transposed();
        int         order [RFT_MAX_LEN];
        int         n, len, rows, per, base, r, k;
        fence_out_t res;
        len  = held_len;
        rows = (rows_cfg == 0) ? 1 : int'(rows_cfg);
        n    = 0;
        if (rows == 1 || len <= rows) begin
            for (k = 0; k < len; k++) begin
                order[n] = k;
                n++;
            end
        end else begin
            per = 2 * rows - 2;
            for (base = 0; base < len; base += per) begin
                order[n] = base;
                n++;
            end
            for (r = 1; r < rows - 1; r++) begin
                for (base = 0; base < len; base += per) begin
                    if (base + r < len) begin
                        order[n] = base + r;
                        n++;
                    end
                    if (base + per - r < len) begin
                        order[n] = base + per - r;
                        n++;
                    end
                end
            end
            for (base = 0; base + rows - 1 < len; base += per) begin
                order[n] = base + rows - 1;
                n++;
            end
        end
        for (k = 0; k < n; k++) begin
            res.data = msg_store[order[k]];
            res.last = (k == n - 1);
            res.ovf  = drop_seen;
            transposed_q.push_back(res);
        end
        held_len = 0;
    endtask

    task automatic absorb_item(msg_item_t it);
        if (held_len < RFT_MAX_LEN) begin
            msg_store[held_len] = it.data;
            held_len++;
        end else begin
            drop_seen = 1'b1;
        end
        if (it.last)
            queue_transposed();
    endtask

    // Sample both channels at the rising edge
    always @(posedge aclk) begin : monitor
        msg_item_t  got_in;
        fence_out_t want;
        s_taken = 1'b0;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                got_in.data = s_in_byte;
                got_in.last = s_in_last;
                absorb_item(got_in);
                s_taken = 1'b1;
            end
            if (m_valid && m_ready) begin
                if (transposed_q.size() == 0) begin
                    $display("%0t: unexpected result: byte=%02h last=%b ovf=%b",
                             $time, m_out_byte, m_out_last, m_overflow);
                    err_count++;
                end else begin
                    want = transposed_q.pop_front();
                    if ({want.data, want.last, want.ovf} !==
                        {m_out_byte, m_out_last, m_overflow}) begin
                        $display("%0t: expected %02h/%b/%b, actual %02h/%b/%b",
                                 $time, want.data, want.last, want.ovf,
                                 m_out_byte, m_out_last, m_overflow);
                        err_count++;
                    end
                end
            end
        end
    end

    int tx_gap = 0;

    always @(negedge aclk) begin : sender
        msg_item_t             nxt;
        logic                  v_n;
        logic [RFT_BYTE_W-1:0] b_n;
        logic                  l_n;
        v_n = s_valid;
        b_n = s_in_byte;
        l_n = s_in_last;
        if (!aresetn) begin
            v_n = 1'b0;
        end else if (!s_valid || s_taken) begin
            v_n = 1'b0;
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (msg_items_q.size() > 0) begin
                if (idle_en && $urandom_range(7) == 0) begin
                    tx_gap = $urandom_range(14);
                end else begin
                    nxt = msg_items_q.pop_front();
                    v_n = 1'b1;
                    b_n = nxt.data;
                    l_n = nxt.last;
                end
            end
        end
        s_valid   <= v_n;
        s_in_byte <= b_n;
        s_in_last <= l_n;
    end

    int rx_gap    = 0;
    int hold_left = 0;
    int hold_seen = 0;

    always @(negedge aclk) begin : receiver
        logic r_n;
        r_n = 1'b1;
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = 400;
        end
        if (!aresetn) begin
            r_n = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            r_n = 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            r_n = 1'b0;
        end else if (idle_en && $urandom_range(5) == 0) begin
            rx_gap = $urandom_range(14);
            r_n    = 1'b0;
        end
        m_ready <= r_n;
    end

    task automatic push_item(logic [RFT_BYTE_W-1:0] data, logic last);
        msg_item_t it;
        it.data = data;
        it.last = last;
        msg_items_q.push_back(it);
    endtask

    task automatic send_msg(int len);
        for (int i = 0; i < len; i++)
            push_item(8'($urandom_range(255)), i == len - 1);
    endtask

    // Wait until every queued transaction has been sent and returned; checked at
    // the rising edge, where the driver's queue and valid are settled
    task automatic wait_drained();
        @(posedge aclk);
        while (msg_items_q.size() != 0 || s_valid || transposed_q.size() != 0)
            @(posedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_rows(logic [RFT_ROWS_W-1:0] v);
        wait_drained();
        cfg_wr_data <= v;
        cfg_wr_en   <= 1'b1;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        rows_cfg     = v;
    endtask

    initial begin : stimulus
        logic [RFT_ROWS_W-1:0] rows_set [6];
        int                    sent, len;
        rows_set = '{7'd2, 7'd127, 7'd5, 7'd64, 7'd3, 7'd9};
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: reset row count first, then one, zero and two rows
        push_item(8'h00, 1'b1);
        push_item(8'hFF, 1'b1);
        push_item(8'h01, 1'b0);
        push_item(8'h80, 1'b0);
        push_item(8'hFE, 1'b1);
        for (int i = 0; i < 7; i++)
            push_item(8'h41 + 8'(i), i == 6);
        write_rows(7'd1);
        push_item(8'hC3, 1'b0);
        push_item(8'h3C, 1'b0);
        push_item(8'h99, 1'b1);
        write_rows(7'd0);
        for (int i = 0; i < 4; i++)
            push_item(8'h10 * 8'(i + 1), i == 3);
        write_rows(7'd2);
        push_item(8'h7F, 1'b0);
        push_item(8'h80, 1'b0);
        push_item(8'h01, 1'b0);
        push_item(8'hFE, 1'b1);

        // Random short messages over a spread of row counts
        for (int ph = 0; ph < 6; ph++) begin
            write_rows(ph == 5 ? 7'($urandom_range(4, 12)) : rows_set[ph]);
            idle_en = ($urandom_range(3) != 0);
            sent = 0;
            while (sent < 5) begin
                len = $urandom_range(1, 10);
                send_msg(len);
                sent += len;
            end
        end

        // Receiver holds off while the sender keeps offering, so both banks fill
        write_rows(7'd4);
        idle_en = 1'b0;
        hold_req++;
        repeat (3) send_msg(6);

        // Full buffer whose tail and last byte are dropped, then a sticky flag check
        write_rows(7'd63);
        send_msg(RFT_MAX_LEN + 2);
        send_msg(3);

        wait_drained();
        repeat (20) @(negedge aclk);
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

>>> rail_fence_transposer.f
design/rft_pkg.sv
design/rft_ram.sv
design/rft_job_queue.sv
design/rft_loader.sv
design/rft_drain.sv
design/rail_fence_transposer.sv
verif/tb_rail_fence_transposer.sv
